// ----- hw/rtl/oadc_pkg.sv -----
// Shared types, constants and reset values of the obstacle-avoiding drive controller.
`default_nettype none

package oadc_pkg;

  // Default configuration of the structure.
  localparam int unsigned WINDOW_DEF      = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Field widths.
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SPEED_W = 15;
  localparam int unsigned STEER_W = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_DIR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM   = 3'd4;

  // Register values after reset.
  localparam logic [DIST_W-1:0]  THRESHOLD_RST = 16'd30;
  localparam logic [SPEED_W-1:0] CRUISE_RST    = 15'd500;
  localparam logic               TURN_DIR_RST  = 1'b0;
  localparam logic [STEER_W-1:0] CENTER_RST    = 15'd1500;
  localparam logic [STEER_W-1:0] MINIMUM_RST   = 15'd1000;

  // Half of the hard steering offset, added to or taken from the center.
  localparam logic [STEER_W+1:0] HALF_TURN = 17'd500;
  localparam logic [STEER_W+1:0] STEER_MAX = 17'd32767;

  // Edge codes of one side.
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_BLOCKED = 2'd1;
  localparam logic [1:0] EVT_FREE    = 2'd2;

  // Drive state codes.
  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_REVERSE = 1'b1;

  // Classified item handed from the front part to the drive machine.
  typedef struct packed {
    logic [1:0] front_event;
    logic [1:0] back_event;
    logic       front_closed;
    logic       back_closed;
  } oadc_cls_t;

  // Configuration seen by the drive machine.
  typedef struct packed {
    logic [SPEED_W-1:0] cruise_speed;
    logic               turn_direction;
    logic [STEER_W-1:0] steering_center;
    logic [STEER_W-1:0] steering_minimum;
  } oadc_cfg_t;

  // Queue status.
  typedef struct packed {
    logic empty;
    logic full;
  } oadc_qstat_t;

  // One result item.
  typedef struct packed {
    logic [SPEED_W:0]   drive_speed;
    logic [STEER_W-1:0] steer_position;
    logic [1:0]         front_event;
    logic [1:0]         back_event;
    logic               front_is_blocked;
    logic               back_is_blocked;
    logic               reversing;
    logic               drive_updated;
  } oadc_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oadc_front.sv -----
// Front part: distance windows, running sums and blocked/free edge detection.
`default_nettype none

module oadc_front #(
  parameter int unsigned WINDOW = oadc_pkg::WINDOW_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire [oadc_pkg::DIST_W-1:0]   front_distance_i,
  input  wire [oadc_pkg::DIST_W-1:0]   back_distance_i,
  input  wire [oadc_pkg::DIST_W-1:0]   threshold_i,
  output oadc_pkg::oadc_cls_t          cls_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = oadc_pkg::DIST_W + $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [oadc_pkg::DIST_W-1:0] front_win_q [WINDOW];
  logic [oadc_pkg::DIST_W-1:0] back_win_q  [WINDOW];
  logic [SLOT_W-1:0]           slot_q, slot_d;
  logic [SUM_W-1:0]            fsum_q, fsum_d, bsum_q, bsum_d;
  logic                        fflag_q, bflag_q;
  logic [SUM_W-1:0]            limit;
  logic                        front_low, back_low;

  // Running sums: drop the oldest sample, add the new one.
  always_comb begin
    fsum_d = fsum_q - SUM_W'(front_win_q[slot_q]) + SUM_W'(front_distance_i);
    bsum_d = bsum_q - SUM_W'(back_win_q[slot_q]) + SUM_W'(back_distance_i);
    limit  = SUM_W'(WINDOW) * SUM_W'(threshold_i);
    front_low = (fsum_d < limit);
    back_low  = (bsum_d < limit);
    slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
  end

  // Edge classification against the flags left by the previous item.
  always_comb begin
    cls_o.front_event = oadc_pkg::EVT_NONE;
    cls_o.back_event  = oadc_pkg::EVT_NONE;
    if (front_low && !fflag_q) begin
      cls_o.front_event = oadc_pkg::EVT_BLOCKED;
    end else if (!front_low && fflag_q) begin
      cls_o.front_event = oadc_pkg::EVT_FREE;
    end
    if (back_low && !bflag_q) begin
      cls_o.back_event = oadc_pkg::EVT_BLOCKED;
    end else if (!back_low && bflag_q) begin
      cls_o.back_event = oadc_pkg::EVT_FREE;
    end
    cls_o.front_closed = front_low;
    cls_o.back_closed  = back_low;
  end

  // Window and flag state, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        front_win_q[i] <= '0;
        back_win_q[i]  <= '0;
      end
      slot_q  <= '0;
      fsum_q  <= '0;
      bsum_q  <= '0;
      fflag_q <= 1'b1;
      bflag_q <= 1'b1;
    end else if (accept_i) begin
      front_win_q[slot_q] <= front_distance_i;
      back_win_q[slot_q]  <= back_distance_i;
      slot_q  <= slot_d;
      fsum_q  <= fsum_d;
      bsum_q  <= bsum_d;
      fflag_q <= front_low;
      bflag_q <= back_low;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/oadc_queue.sv -----
// Short FIFO that decouples the edge detector from the drive machine.
`default_nettype none

module oadc_queue #(
  parameter int unsigned DEPTH = oadc_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = $bits(oadc_pkg::oadc_cls_t)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [WIDTH-1:0]  wdata_i,
  input  wire              pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output oadc_pkg::oadc_qstat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pointer wrap and fill count.
  always_comb begin
    wptr_d  = (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
    rptr_d  = (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
    count_d = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FULL_CNT);

  // Entry storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_d;
      end
      if (pop_i) begin
        rptr_q <= rptr_d;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/oadc_back.sv -----
// Back part: forward/reverse drive machine and the registered result stage.
`default_nettype none

module oadc_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cls_valid_i,
  input  wire oadc_pkg::oadc_cls_t cls_i,
  input  wire oadc_pkg::oadc_cfg_t cfg_i,
  output logic                  cls_pop_o,
  output logic                  res_valid_o,
  input  wire                   res_ready_i,
  output oadc_pkg::oadc_res_t   res_o
);

  localparam int unsigned STEER_W = oadc_pkg::STEER_W;
  localparam int unsigned SPEED_W = oadc_pkg::SPEED_W;

  logic                 mode_q, mode_d, mode_mid;
  logic [SPEED_W:0]     speed_q, speed_d;
  logic [STEER_W-1:0]   steer_q, steer_d;
  logic                 updated;
  logic                 res_valid_q, res_valid_d;
  oadc_pkg::oadc_res_t  res_q, res_d;
  logic [STEER_W+1:0]   turn_pos;
  logic [STEER_W-1:0]   turn_steer;
  logic [SPEED_W:0]     fwd_speed, rev_speed;

  // Hard steering position: center plus or minus half the turn offset.
  always_comb begin
    if (cfg_i.turn_direction) begin
      turn_pos   = {2'b00, cfg_i.steering_center} + oadc_pkg::HALF_TURN;
      turn_steer = (turn_pos > oadc_pkg::STEER_MAX) ? STEER_W'(oadc_pkg::STEER_MAX)
                                                    : turn_pos[STEER_W-1:0];
    end else begin
      turn_pos   = {2'b00, cfg_i.steering_center} - oadc_pkg::HALF_TURN;
      turn_steer = turn_pos[STEER_W+1] ? cfg_i.steering_minimum : turn_pos[STEER_W-1:0];
    end
    fwd_speed = {1'b0, cfg_i.cruise_speed};
    rev_speed = -fwd_speed;
  end

  // Front edge first, then the back edge on the mode it leaves.
  always_comb begin
    mode_d  = mode_q;
    speed_d = speed_q;
    steer_d = steer_q;
    updated = 1'b0;
    if (mode_q == oadc_pkg::MODE_FORWARD) begin
      if (cls_i.front_event == oadc_pkg::EVT_FREE) begin
        speed_d = fwd_speed;
        updated = 1'b1;
      end else if (cls_i.front_event == oadc_pkg::EVT_BLOCKED) begin
        steer_d = turn_steer;
        speed_d = rev_speed;
        mode_d  = oadc_pkg::MODE_REVERSE;
        updated = 1'b1;
      end
    end
    mode_mid = mode_d;
    if (mode_mid == oadc_pkg::MODE_REVERSE &&
        cls_i.back_event == oadc_pkg::EVT_BLOCKED) begin
      steer_d = cfg_i.steering_center;
      speed_d = fwd_speed;
      mode_d  = oadc_pkg::MODE_FORWARD;
      updated = 1'b1;
    end
  end

  // Result stage takes a new entry whenever it is empty or being drained.
  assign cls_pop_o = cls_valid_i && (!res_valid_q || res_ready_i);

  always_comb begin
    res_d.drive_speed      = speed_d;
    res_d.steer_position   = steer_d;
    res_d.front_event      = cls_i.front_event;
    res_d.back_event       = cls_i.back_event;
    res_d.front_is_blocked = cls_i.front_closed;
    res_d.back_is_blocked  = cls_i.back_closed;
    res_d.reversing        = mode_d;
    res_d.drive_updated    = updated;
    if (cls_pop_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // Drive state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= oadc_pkg::MODE_FORWARD;
      speed_q     <= '0;
      steer_q     <= oadc_pkg::CENTER_RST;
      res_valid_q <= 1'b0;
    end else begin
      if (cls_pop_o) begin
        mode_q  <= mode_d;
        speed_q <= speed_d;
        steer_q <= steer_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cls_pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/obstacle_avoid_drive_controller.sv -----
// Top level of the obstacle-avoiding drive controller: configuration, front, queue, back.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   front/back distance readings
// m_axis    out        m_axis_tvalid/m_axis_tready   drive command and status
// cfg       in         cfg_valid_i/cfg_ready_o       register index and write data
//
// One request is accepted per cycle while the queue is not full. An accepted request
// passes through the queue and then the registered result stage before m_axis_tvalid
// rises for it. Reset clears the windows and drive state and sets both blocked flags
// at once; no clearing pass follows. A queue of QUEUE_DEPTH entries separates the
// edge detector from the drive machine; s_axis_tready drops only while that queue is
// full. cfg_ready_o is always high.
`default_nettype none

module obstacle_avoid_drive_controller #(
  parameter int unsigned WINDOW      = oadc_pkg::WINDOW_DEF,
  parameter int unsigned QUEUE_DEPTH = oadc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Fields from bit 0: front_distance[15:0], back_distance[31:16].
  input  wire  [31:0] s_axis_tdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: drive_speed[15:0], steer_position[30:16], front_event[32:31],
  // back_event[34:33], front_is_blocked[35], back_is_blocked[36], reversing[37],
  // drive_updated[38], zero fill[39].
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [oadc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [oadc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CLS_W = $bits(oadc_pkg::oadc_cls_t);

  logic [oadc_pkg::DIST_W-1:0] threshold_q;
  oadc_pkg::oadc_cfg_t         cfg_q;
  logic                        in_accept;
  logic                        cls_pop;
  oadc_pkg::oadc_cls_t         cls_front, cls_queue;
  logic [CLS_W-1:0]            cls_queue_bits;
  oadc_pkg::oadc_qstat_t       qstat;
  oadc_pkg::oadc_res_t         res;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q            <= oadc_pkg::THRESHOLD_RST;
      cfg_q.cruise_speed     <= oadc_pkg::CRUISE_RST;
      cfg_q.turn_direction   <= oadc_pkg::TURN_DIR_RST;
      cfg_q.steering_center  <= oadc_pkg::CENTER_RST;
      cfg_q.steering_minimum <= oadc_pkg::MINIMUM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        oadc_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        oadc_pkg::CFG_CRUISE:    cfg_q.cruise_speed <= cfg_data_i[oadc_pkg::SPEED_W-1:0];
        oadc_pkg::CFG_TURN_DIR:  cfg_q.turn_direction <= cfg_data_i[0];
        oadc_pkg::CFG_CENTER:    cfg_q.steering_center <= cfg_data_i[oadc_pkg::STEER_W-1:0];
        oadc_pkg::CFG_MINIMUM:   cfg_q.steering_minimum <= cfg_data_i[oadc_pkg::STEER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign s_axis_tready = !qstat.full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  oadc_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .front_distance_i (s_axis_tdata[15:0]),
    .back_distance_i  (s_axis_tdata[31:16]),
    .threshold_i      (threshold_q),
    .cls_o            (cls_front)
  );

  oadc_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (CLS_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (cls_front),
    .pop_i   (cls_pop),
    .rdata_o (cls_queue_bits),
    .stat_o  (qstat)
  );

  assign cls_queue = cls_queue_bits;

  oadc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (!qstat.empty),
    .cls_i       (cls_queue),
    .cfg_i       (cfg_q),
    .cls_pop_o   (cls_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Output packing, first field in the low bits.
  assign m_axis_tdata = {1'b0, res.drive_updated, res.reversing, res.back_is_blocked,
                         res.front_is_blocked, res.back_event, res.front_event,
                         res.steer_position, res.drive_speed};

  // An accepted request always leaves the queue non-empty on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> !qstat.empty)
    else $error("queue empty right after an accepted request");

  // Reverse mode always carries a reverse or zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.reversing) |-> $signed(res.drive_speed) <= 0)
    else $error("reversing with a forward speed");

  // A motor command is only issued on an edge of one of the sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.drive_updated) |->
      (res.front_event != oadc_pkg::EVT_NONE || res.back_event != oadc_pkg::EVT_NONE))
    else $error("drive command without an edge");

  // The drive machine never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cls_pop |-> !qstat.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the obstacle-avoiding drive controller.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN          = oadc_pkg::WINDOW_DEF;
  localparam int          HARD_TURN    = 1000;
  localparam int          STEER_LIMIT  = int'(oadc_pkg::STEER_MAX);
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;
  // First index past the register list; writes there must change nothing.
  localparam logic [oadc_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = oadc_pkg::CFG_MINIMUM + 3'd1;

  // Result layout on m_axis_tdata, highest field first.
  typedef struct packed {
    logic                         fill;
    logic                         drive_updated;
    logic                         reversing;
    logic                         back_is_blocked;
    logic                         front_is_blocked;
    logic [1:0]                   back_event;
    logic [1:0]                   front_event;
    logic [oadc_pkg::STEER_W-1:0] steer_position;
    logic [oadc_pkg::SPEED_W:0]   drive_speed;
  } drive_cmd_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SELDOM,
    READY_PERIODIC
  } stall_style_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic [31:0]                     s_axis_tdata  = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [39:0]                     m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [oadc_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [oadc_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  obstacle_avoid_drive_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predicted controller state and its copy of the registers.
  logic [oadc_pkg::DIST_W-1:0]  front_win [WIN] = '{default: '0};
  logic [oadc_pkg::DIST_W-1:0]  back_win  [WIN] = '{default: '0};
  int unsigned                  win_slot        = 0;
  logic                         front_blk       = 1'b1;
  logic                         back_blk        = 1'b1;
  logic                         drive_mode      = oadc_pkg::MODE_FORWARD;
  logic [oadc_pkg::SPEED_W:0]   speed_cmd       = '0;
  logic [oadc_pkg::STEER_W-1:0] steer_cmd       = oadc_pkg::CENTER_RST;
  logic [oadc_pkg::DIST_W-1:0]  thr_cfg         = oadc_pkg::THRESHOLD_RST;
  logic [oadc_pkg::SPEED_W-1:0] cruise_cfg      = oadc_pkg::CRUISE_RST;
  logic                         turn_cfg        = oadc_pkg::TURN_DIR_RST;
  logic [oadc_pkg::STEER_W-1:0] center_cfg      = oadc_pkg::CENTER_RST;
  logic [oadc_pkg::STEER_W-1:0] minimum_cfg     = oadc_pkg::MINIMUM_RST;

  logic [31:0]  pending_readings [$];
  drive_cmd_t   expected_cmds [$];
  int unsigned  mismatches   = 0;
  int unsigned  result_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  burst_left   = 0;
  int unsigned  gap_left     = 0;
  int unsigned  stall_cycle  = 0;
  int unsigned  stall_len    = 0;
  stall_style_e stall_style  = READY_ALWAYS;

  // Servo position for an offset: capped at the top, the minimum when negative.
  function automatic logic [oadc_pkg::STEER_W-1:0] steer_for_offset(input int offset);
    int pos;
    pos = int'(center_cfg) + offset / 2;
    if (pos < 0) return minimum_cfg;
    if (pos > STEER_LIMIT) return oadc_pkg::STEER_W'(STEER_LIMIT);
    return oadc_pkg::STEER_W'(pos);
  endfunction

  // Drive machine reaction to one side's edge; returns 1 when a command is issued.
  function automatic bit drive_react(input bit from_front, input logic [1:0] evt);
    if (drive_mode == oadc_pkg::MODE_FORWARD && from_front && evt == oadc_pkg::EVT_FREE) begin
      speed_cmd = {1'b0, cruise_cfg};
      return 1'b1;
    end
    if (drive_mode == oadc_pkg::MODE_FORWARD && from_front &&
        evt == oadc_pkg::EVT_BLOCKED) begin
      steer_cmd  = steer_for_offset(turn_cfg ? HARD_TURN : -HARD_TURN);
      speed_cmd  = -{1'b0, cruise_cfg};
      drive_mode = oadc_pkg::MODE_REVERSE;
      return 1'b1;
    end
    if (drive_mode == oadc_pkg::MODE_REVERSE && !from_front &&
        evt == oadc_pkg::EVT_BLOCKED) begin
      steer_cmd  = steer_for_offset(0);
      speed_cmd  = {1'b0, cruise_cfg};
      drive_mode = oadc_pkg::MODE_FORWARD;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Window update, edge detection and drive reaction for one request.
  function automatic drive_cmd_t predict_command(input logic [oadc_pkg::DIST_W-1:0] front,
                                                 input logic [oadc_pkg::DIST_W-1:0] back);
    int unsigned fsum;
    int unsigned bsum;
    int unsigned limit;
    bit          upd;
    drive_cmd_t  cmd;
    cmd  = '0;
    upd  = 1'b0;
    fsum = 0;
    bsum = 0;
    front_win[win_slot] = front;
    back_win[win_slot]  = back;
    win_slot = (win_slot + 1 >= WIN) ? 0 : win_slot + 1;
    for (int i = 0; i < WIN; i++) begin
      fsum += 32'(front_win[i]);
      bsum += 32'(back_win[i]);
    end
    limit = WIN * 32'(thr_cfg);
    // The front edge acts first, so the back edge sees the mode it leaves.
    if (fsum < limit && !front_blk) begin
      front_blk = 1'b1;
      cmd.front_event = oadc_pkg::EVT_BLOCKED;
      upd |= drive_react(1'b1, oadc_pkg::EVT_BLOCKED);
    end else if (fsum >= limit && front_blk) begin
      front_blk = 1'b0;
      cmd.front_event = oadc_pkg::EVT_FREE;
      upd |= drive_react(1'b1, oadc_pkg::EVT_FREE);
    end
    if (bsum < limit && !back_blk) begin
      back_blk = 1'b1;
      cmd.back_event = oadc_pkg::EVT_BLOCKED;
      upd |= drive_react(1'b0, oadc_pkg::EVT_BLOCKED);
    end else if (bsum >= limit && back_blk) begin
      back_blk = 1'b0;
      cmd.back_event = oadc_pkg::EVT_FREE;
      upd |= drive_react(1'b0, oadc_pkg::EVT_FREE);
    end
    cmd.drive_speed      = speed_cmd;
    cmd.steer_position   = steer_cmd;
    cmd.front_is_blocked = front_blk;
    cmd.back_is_blocked  = back_blk;
    cmd.reversing        = drive_mode;
    cmd.drive_updated    = upd;
    return cmd;
  endfunction

  // Register write as seen by the predictor; unknown indexes are dropped.
  function automatic void apply_cfg(input logic [oadc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [oadc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      oadc_pkg::CFG_THRESHOLD: thr_cfg     = val;
      oadc_pkg::CFG_CRUISE:    cruise_cfg  = val[oadc_pkg::SPEED_W-1:0];
      oadc_pkg::CFG_TURN_DIR:  turn_cfg    = val[0];
      oadc_pkg::CFG_CENTER:    center_cfg  = val[oadc_pkg::STEER_W-1:0];
      oadc_pkg::CFG_MINIMUM:   minimum_cfg = val[oadc_pkg::STEER_W-1:0];
      default: ;
    endcase
  endfunction

  // A distance that pushes a side toward blocked or free, with some near misses.
  function automatic logic [oadc_pkg::DIST_W-1:0] pick_distance(input bit want_blocked);
    int near;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: return 16'($urandom);
      2, 3: begin
        near = int'(thr_cfg) + int'($urandom_range(0, 4)) - 2;
        return (near < 0) ? 16'h0000 : (near > 65535) ? 16'hFFFF : 16'(near);
      end
      default: begin
        if (!want_blocked) return 16'($urandom_range(thr_cfg, 16'hFFFF));
        return (thr_cfg == 0) ? 16'h0000 : 16'($urandom_range(0, thr_cfg - 1));
      end
    endcase
  endfunction

  task automatic push_reading(input logic [oadc_pkg::DIST_W-1:0] front,
                              input logic [oadc_pkg::DIST_W-1:0] back);
    pending_readings.push_back({back, front});
  endtask

  // Runs of near and clear readings on each side, so the machine sees many edges.
  task automatic queue_obstacle_course(input int unsigned count);
    bit          front_want;
    bit          back_want;
    int unsigned front_run;
    int unsigned back_run;
    front_want = $urandom_range(0, 1);
    back_want  = $urandom_range(0, 1);
    front_run  = 0;
    back_run   = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (front_run == 0) begin
        front_want = ($urandom_range(0, 4) == 0) ? front_want : !front_want;
        front_run  = $urandom_range(1, 8);
      end
      if (back_run == 0) begin
        back_want = ($urandom_range(0, 4) == 0) ? back_want : !back_want;
        back_run  = $urandom_range(1, 8);
      end
      front_run--;
      back_run--;
      if ($urandom_range(0, 9) == 0) begin
        push_reading(16'($urandom), 16'($urandom));
      end else begin
        push_reading(pick_distance(front_want), pick_distance(back_want));
      end
    end
  endtask

  // Returns at a clock edge once no request is queued, on the bus or expected.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_readings.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0);
  endtask

  // Valid stays high across back-to-back writes and is lowered by the caller.
  task automatic write_reg(input logic [oadc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [oadc_pkg::CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    apply_cfg(idx, val);
  endtask

  task automatic set_config(input logic [oadc_pkg::CFG_DATA_W-1:0] thr,
                            input logic [oadc_pkg::CFG_DATA_W-1:0] cruise,
                            input logic [oadc_pkg::CFG_DATA_W-1:0] turn,
                            input logic [oadc_pkg::CFG_DATA_W-1:0] center,
                            input logic [oadc_pkg::CFG_DATA_W-1:0] minimum);
    write_reg(oadc_pkg::CFG_THRESHOLD, thr);
    write_reg(oadc_pkg::CFG_CRUISE, cruise);
    write_reg(oadc_pkg::CFG_TURN_DIR, turn);
    write_reg(oadc_pkg::CFG_CENTER, center);
    write_reg(oadc_pkg::CFG_MINIMUM, minimum);
    write_reg(CFG_SPARE_FIRST + oadc_pkg::CFG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("result %0d: %s expected %0d, got %0d", result_count, name, exp_v, got_v);
      end
    end
  endtask

  // Stimulus: directed sequence at reset settings, then random courses per setting.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_reading(16'h0000, 16'h0000);
    push_reading(16'hFFFF, 16'hFFFF);
    repeat (3) push_reading(16'h0000, 16'hFFFF);
    repeat (3) push_reading(16'hFFFF, 16'h0000);
    repeat (3) push_reading(16'hFFFF, 16'hFFFF);
    // Both sides turn blocked in the same request.
    repeat (3) push_reading(16'h0000, 16'h0000);
    // A window sum equal to the limit counts as free.
    repeat (3) push_reading(oadc_pkg::THRESHOLD_RST, oadc_pkg::THRESHOLD_RST);
    push_reading(oadc_pkg::THRESHOLD_RST - 16'd1, oadc_pkg::THRESHOLD_RST);
    push_reading(oadc_pkg::THRESHOLD_RST + 16'd1, oadc_pkg::THRESHOLD_RST - 16'd1);
    push_reading(16'h5555, 16'hAAAA);
    push_reading(16'hAAAA, 16'h5555);
    queue_obstacle_course(60);
    wait_idle();

    // Saturated steering, then a negative position that falls back to the minimum.
    set_config(16'd0, 16'd32767, 16'd1, 16'd32767, 16'd0);
    queue_obstacle_course(52);
    wait_idle();
    set_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd32767);
    queue_obstacle_course(52);
    wait_idle();
    set_config(16'd100, 16'd1234, 16'd0, 16'd300, 16'd77);
    queue_obstacle_course(52);
    wait_idle();
    set_config(16'd5, 16'd32767, 16'd1, 16'd30000, 16'd30000);
    queue_obstacle_course(52);
    wait_idle();

    // Random settings; upper data bits of the narrow registers are noise.
    repeat (5) begin
      set_config(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 200)),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_obstacle_course(52);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(predict_command(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          s_axis_tdata  <= pending_readings.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each drive command and applies receiver stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("result %0d: unexpected command %h", result_count, m_axis_tdata);
          end
        end else begin
          drive_cmd_t want;
          drive_cmd_t got;
          want = expected_cmds.pop_front();
          got  = drive_cmd_t'(m_axis_tdata);
          check_field("drive_speed", int'($signed(want.drive_speed)),
                      int'($signed(got.drive_speed)));
          check_field("steer_position", int'(want.steer_position),
                      int'(got.steer_position));
          check_field("front_event", int'(want.front_event), int'(got.front_event));
          check_field("back_event", int'(want.back_event), int'(got.back_event));
          check_field("front_is_blocked", int'(want.front_is_blocked),
                      int'(got.front_is_blocked));
          check_field("back_is_blocked", int'(want.back_is_blocked),
                      int'(got.back_is_blocked));
          check_field("reversing", int'(want.reversing), int'(got.reversing));
          check_field("drive_updated", int'(want.drive_updated), int'(got.drive_updated));
          check_field("fill", int'(want.fill), int'(got.fill));
        end
      end
      stall_cycle++;
      if (stall_cycle >= stall_len) begin
        stall_cycle = 0;
        stall_len   = $urandom_range(16, 80);
        stall_style = stall_style_e'($urandom_range(0, 3));
      end
      case (stall_style)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        READY_SELDOM: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:      m_axis_tready <= ((stall_cycle % 5) < 2);
      endcase
    end
  end

  // Watchdog: ends the run when no channel moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/oadc_pkg.sv
hw/rtl/oadc_front.sv
hw/rtl/oadc_queue.sv
hw/rtl/oadc_back.sv
hw/rtl/obstacle_avoid_drive_controller.sv
tb/sv/tb.sv
